// ===== src/nga_pkg.sv =====
// Package for the n-body gravity accumulate and integrate core.
// Holds fixed-point constants, operation and register codes, shared structs
// and saturating arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nga_pkg;

    localparam int FRAC_BITS = 32;
    localparam int ACC_SHIFT = 128 - FRAC_BITS;
    localparam logic [127:0] EPS_Q =
        ((128'd1 << (2 * FRAC_BITS)) + 128'd5000) / 128'd10000;
    localparam logic [30:0] G_Q64 = 31'd1230951232;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FORCE = 2'd2,
        OP_STEP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_VEL_X = 3'd2,
        CFG_VEL_Y = 3'd3,
        CFG_DT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ0,
        ST_SQ1,
        ST_ROOT,
        ST_AXIS,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_MULM,
        ST_MULG,
        ST_ACC,
        ST_VEL,
        ST_POS,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic signed [63:0] ox;
        logic signed [63:0] oy;
        logic [47:0]        mass;
    } cmd_t;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] vel_x;
        logic [63:0] vel_y;
        logic [62:0] dt;
    } cfg_t;

    typedef struct packed {
        logic         start;
        logic [255:0] a;
        logic [63:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [255:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic         start;
        logic [127:0] dvd;
        logic [63:0]  dsr;
    } div_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic         start;
        logic [127:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } back_stat_t;

    function automatic logic [63:0] clamp66(input logic [65:0] sum);
        logic [63:0] res;
        if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111)
            res = sum[63:0];
        else if (sum[65])
            res = S64_MIN;
        else
            res = S64_MAX;
        return res;
    endfunction

    function automatic logic [63:0] sat_add_mag(input logic [63:0] v, input logic neg,
                                                input logic [63:0] mag);
        logic [65:0] ve;
        logic [65:0] me;
        ve = {{2{v[63]}}, v};
        me = {2'b00, mag};
        return clamp66(neg ? (ve - me) : (ve + me));
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [65:0] ae;
        logic [65:0] be;
        ae = {{2{a[63]}}, a};
        be = {{2{b[63]}}, b};
        return clamp66(ae - be);
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== src/nga_in_if.sv =====
// Input channel: valid/ready handshake carrying one operation beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface nga_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [63:0] other_pos_x;
    logic signed [63:0] other_pos_y;
    logic [47:0]        other_mass;

    modport source (output valid, output op, output other_pos_x, output other_pos_y,
                    output other_mass, input ready);
    modport sink (input valid, input op, input other_pos_x, input other_pos_y,
                  input other_mass, output ready);
endinterface
`default_nettype wire

// ===== src/nga_out_if.sv =====
// Output channel: valid/ready handshake carrying one body-state beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface nga_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] pos_x_out;
    logic signed [63:0] pos_y_out;
    logic signed [63:0] vel_x_out;
    logic signed [63:0] vel_y_out;

    modport source (output valid, output pos_x_out, output pos_y_out, output vel_x_out,
                    output vel_y_out, input ready);
    modport sink (input valid, input pos_x_out, input pos_y_out, input vel_x_out,
                  input vel_y_out, output ready);
endinterface
`default_nettype wire

// ===== src/nbody_gravity_accumulate_integrate_core.sv =====
// Single-body 2D gravity accumulator with semi-implicit Euler step, Q32.32.
// Load and clear go straight to the result; step runs four multiplies; force runs two
// squares, a square root and, per nonzero axis, three bit-serial divisions and two multiplies.
// Throughput: one item in the back end at a time; two more wait in the input queue.
// Reset (rst_n low, asynchronous) zeroes the register port and body state, empties the queue and drops output valid.
`timescale 1ns / 1ps
`default_nettype none
module nbody_gravity_accumulate_integrate_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    nga_in_if.sink           in,
    nga_out_if.source        out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import nga_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    mul_req_t   mul_req;
    mul_rsp_t   mul_rsp;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    sqrt_req_t  sqrt_req;
    sqrt_rsp_t  sqrt_rsp;
    back_stat_t stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POS_X: cfg_next.pos_x = cfg_data;
                CFG_POS_Y: cfg_next.pos_y = cfg_data;
                CFG_VEL_X: cfg_next.vel_x = cfg_data;
                CFG_VEL_Y: cfg_next.vel_y = cfg_data;
                CFG_DT:    cfg_next.dt    = cfg_data[62:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    nga_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    nga_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    nga_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    nga_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    nga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .sqrt_req  (sqrt_req),
        .sqrt_rsp  (sqrt_rsp),
        .stat      (stat),
        .out       (out)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready) |=> cmd_valid)
        else $error("accepted beat lost from queue");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out.valid) |-> $past(stat.done))
        else $error("result raised outside completion");
endmodule
`default_nettype wire

// ===== src/nga_mul.sv =====
// Shared multiplier: 256 x 64 bit product, one 32 x 32 partial product a cycle.
// Depends on nga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nga_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nga_pkg::mul_req_t req,
    output nga_pkg::mul_rsp_t      rsp
);
    import nga_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [2:0]   i_reg, i_next;
    logic         j_reg, j_next;
    logic [255:0] a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [255:0] acc_reg, acc_next;
    logic [63:0]  pp;
    logic [3:0]   lsh;

    always_comb
    begin
        pp        = 64'(a_reg[{i_reg, 5'b0} +: 32]) * 64'(b_reg[{j_reg, 5'b0} +: 32]);
        lsh       = {1'b0, i_reg} + {3'b000, j_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        j_next    = j_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            i_next    = 3'd0;
            j_next    = 1'b0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (256'(pp) << {lsh, 5'b0});
            j_next   = ~j_reg;
            if (j_reg)
                i_next = i_reg + 3'd1;
            if (j_reg && i_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule
`default_nettype wire

// ===== src/nga_div.sv =====
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Depends on nga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nga_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nga_pkg::div_req_t req,
    output nga_pkg::div_rsp_t      rsp
);
    import nga_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] dvd_reg, dvd_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  dsr_reg, dsr_next;
    logic [64:0]  remsh;
    logic         ge;

    always_comb
    begin
        remsh     = {rem_reg, dvd_reg[127]};
        ge        = remsh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dvd;
            rem_next  = '0;
            dsr_next  = (req.dsr == 64'd0) ? 64'd1 : req.dsr;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 64'(remsh - {1'b0, dsr_reg}) : remsh[63:0];
            dvd_next = {dvd_reg[126:0], ge};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg;
endmodule
`default_nettype wire

// ===== src/nga_sqrt.sv =====
// Integer square root of a 128-bit radicand, one root bit a cycle.
// Depends on nga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nga_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nga_pkg::sqrt_req_t req,
    output nga_pkg::sqrt_rsp_t      rsp
);
    import nga_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [127:0] rad_reg, rad_next;
    logic [63:0]  root_reg, root_next;
    logic [65:0]  rem_reg, rem_next;
    logic [67:0]  remsh;
    logic [67:0]  trial;
    logic         ge;

    always_comb
    begin
        remsh     = {rem_reg, rad_reg[127:126]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = remsh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = req.rad;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 66'(remsh - trial) : remsh[65:0];
            root_next = {root_reg[62:0], ge};
            rad_next  = {rad_reg[125:0], 2'b00};
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule
`default_nettype wire

// ===== src/nga_front.sv =====
// Front end: accept input beats, decode the operation, hold them in a two-entry queue.
// Depends on nga_pkg and nga_in_if.
`timescale 1ns / 1ps
`default_nettype none
module nga_front (
    input  wire logic clk,
    input  wire logic rst_n,
    nga_in_if.sink    in,
    output logic      cmd_valid,
    output nga_pkg::cmd_t cmd,
    input  wire logic cmd_pop
);
    import nga_pkg::*;

    cmd_t       q_mem [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic       push;
    cmd_t       entry;

    always_comb
    begin
        in.ready   = cnt_reg != 2'd2;
        push       = in.valid && in.ready;
        entry.op   = op_t'(in.op);
        entry.ox   = in.other_pos_x;
        entry.oy   = in.other_pos_y;
        entry.mass = in.other_mass;
        wr_next    = push ? ~wr_reg : wr_reg;
        rd_next    = cmd_pop ? ~rd_reg : rd_reg;
        cnt_next   = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_reg] <= entry;
    end

    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_mem[rd_reg];
endmodule
`default_nettype wire

// ===== src/nga_back.sv =====
// Back end: sequence each queued operation over the shared arithmetic units
// and register the resulting body state. Depends on nga_pkg and nga_out_if.
`timescale 1ns / 1ps
`default_nettype none
module nga_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire nga_pkg::cmd_t      cmd,
    output logic                    cmd_pop,
    input  wire nga_pkg::cfg_t      cfg,
    output nga_pkg::mul_req_t       mul_req,
    input  wire nga_pkg::mul_rsp_t  mul_rsp,
    output nga_pkg::div_req_t       div_req,
    input  wire nga_pkg::div_rsp_t  div_rsp,
    output nga_pkg::sqrt_req_t      sqrt_req,
    input  wire nga_pkg::sqrt_rsp_t sqrt_rsp,
    output nga_pkg::back_stat_t     stat,
    nga_out_if.source               out
);
    import nga_pkg::*;

    back_state_t  state_reg, state_next;
    logic         go_reg, go_next;
    logic         axis_reg, axis_next;
    logic         outv_reg, outv_next;
    logic [63:0]  pos_reg [2];
    logic [63:0]  pos_next [2];
    logic [63:0]  vel_reg [2];
    logic [63:0]  vel_next [2];
    logic [63:0]  acc_reg [2];
    logic [63:0]  acc_next [2];
    logic [63:0]  u_reg [2];
    logic [63:0]  u_next [2];
    logic         neg_reg [2];
    logic         neg_next [2];
    cmd_t         cmd_reg, cmd_next;
    logic [127:0] s_reg, s_next;
    logic [63:0]  r_reg, r_next;
    logic [255:0] t_reg, t_next;
    logic [63:0]  o_reg [4];
    logic [63:0]  o_next [4];
    logic [63:0]  d0, d1;
    logic [255:0] sh_acc;
    logic [255:0] sh_step;
    logic [63:0]  mag_acc;
    logic [63:0]  mag_step;

    always_comb
    begin
        d0       = sat_sub(cmd_reg.ox, pos_reg[0]);
        d1       = sat_sub(cmd_reg.oy, pos_reg[1]);
        sh_acc   = t_reg >> ACC_SHIFT;
        mag_acc  = (|sh_acc[255:63]) ? S64_MAX : sh_acc[63:0];
        sh_step  = mul_rsp.prod >> FRAC_BITS;
        mag_step = (|sh_step[255:64]) ? '1 : sh_step[63:0];

        state_next = state_reg;
        go_next    = 1'b0;
        axis_next  = axis_reg;
        outv_next  = outv_reg;
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        acc_next   = acc_reg;
        u_next     = u_reg;
        neg_next   = neg_reg;
        cmd_next   = cmd_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        t_next     = t_reg;
        o_next     = o_reg;
        cmd_pop    = 1'b0;
        mul_req    = '0;
        div_req    = '0;
        sqrt_req   = '0;

        if (outv_reg && out.ready)
            outv_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        OP_LOAD:
                        begin
                            pos_next[0] = cfg.pos_x;
                            pos_next[1] = cfg.pos_y;
                            vel_next[0] = cfg.vel_x;
                            vel_next[1] = cfg.vel_y;
                            acc_next[0] = '0;
                            acc_next[1] = '0;
                            state_next  = ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            acc_next[0] = '0;
                            acc_next[1] = '0;
                            state_next  = ST_DONE;
                        end
                        OP_FORCE:
                            state_next = ST_DIFF;
                        OP_STEP:
                        begin
                            axis_next  = 1'b0;
                            go_next    = 1'b1;
                            state_next = ST_VEL;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIFF:
            begin
                u_next[0]   = mag64(d0);
                u_next[1]   = mag64(d1);
                neg_next[0] = d0[63];
                neg_next[1] = d1[63];
                go_next     = 1'b1;
                state_next  = ST_SQ0;
            end
            ST_SQ0:
            begin
                mul_req.start = go_reg;
                mul_req.a     = 256'(u_reg[0]);
                mul_req.b     = u_reg[0];
                if (mul_rsp.done)
                begin
                    s_next     = mul_rsp.prod[127:0];
                    go_next    = 1'b1;
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1:
            begin
                mul_req.start = go_reg;
                mul_req.a     = 256'(u_reg[1]);
                mul_req.b     = u_reg[1];
                if (mul_rsp.done)
                begin
                    s_next     = s_reg + mul_rsp.prod[127:0] + EPS_Q;
                    go_next    = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                sqrt_req.start = go_reg;
                sqrt_req.rad   = s_reg;
                if (sqrt_rsp.done)
                begin
                    r_next     = (sqrt_rsp.root == 64'd0) ? 64'd1 : sqrt_rsp.root;
                    axis_next  = 1'b0;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (u_reg[axis_reg] == 64'd0)
                begin
                    if (axis_reg)
                        state_next = ST_DONE;
                    else
                        axis_next = 1'b1;
                end
                else
                begin
                    go_next    = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                div_req.start = go_reg;
                div_req.dvd   = {u_reg[axis_reg], 64'd0};
                div_req.dsr   = r_reg;
                if (div_rsp.done)
                begin
                    t_next     = 256'(div_rsp.quo);
                    go_next    = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2, ST_DIV3:
            begin
                div_req.start = go_reg;
                div_req.dvd   = t_reg[127:0] << FRAC_BITS;
                div_req.dsr   = r_reg;
                if (div_rsp.done)
                begin
                    t_next     = 256'(div_rsp.quo);
                    go_next    = 1'b1;
                    state_next = (state_reg == ST_DIV2) ? ST_DIV3 : ST_MULM;
                end
            end
            ST_MULM:
            begin
                mul_req.start = go_reg;
                mul_req.a     = t_reg;
                mul_req.b     = 64'(cmd_reg.mass);
                if (mul_rsp.done)
                begin
                    t_next     = mul_rsp.prod;
                    go_next    = 1'b1;
                    state_next = ST_MULG;
                end
            end
            ST_MULG:
            begin
                mul_req.start = go_reg;
                mul_req.a     = t_reg;
                mul_req.b     = 64'(G_Q64);
                if (mul_rsp.done)
                begin
                    t_next     = mul_rsp.prod;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next[axis_reg] = sat_add_mag(acc_reg[axis_reg], neg_reg[axis_reg], mag_acc);
                if (axis_reg)
                    state_next = ST_DONE;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_AXIS;
                end
            end
            ST_VEL:
            begin
                mul_req.start = go_reg;
                mul_req.a     = 256'(mag64(acc_reg[axis_reg]));
                mul_req.b     = 64'(cfg.dt);
                if (mul_rsp.done)
                begin
                    vel_next[axis_reg] = sat_add_mag(vel_reg[axis_reg], acc_reg[axis_reg][63],
                                                     mag_step);
                    go_next   = 1'b1;
                    axis_next = ~axis_reg;
                    if (axis_reg)
                        state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                mul_req.start = go_reg;
                mul_req.a     = 256'(mag64(vel_reg[axis_reg]));
                mul_req.b     = 64'(cfg.dt);
                if (mul_rsp.done)
                begin
                    pos_next[axis_reg] = sat_add_mag(pos_reg[axis_reg], vel_reg[axis_reg][63],
                                                     mag_step);
                    axis_next = ~axis_reg;
                    if (axis_reg)
                        state_next = ST_DONE;
                    else
                        go_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!outv_reg || out.ready)
                begin
                    o_next[0]  = pos_reg[0];
                    o_next[1]  = pos_reg[1];
                    o_next[2]  = vel_reg[0];
                    o_next[3]  = vel_reg[1];
                    outv_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            axis_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            pos_reg   <= '{default: '0};
            vel_reg   <= '{default: '0};
            acc_reg   <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            axis_reg  <= axis_next;
            outv_reg  <= outv_next;
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        neg_reg <= neg_next;
        cmd_reg <= cmd_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        t_reg   <= t_next;
        o_reg   <= o_next;
    end

    assign out.valid     = outv_reg;
    assign out.pos_x_out = o_reg[0];
    assign out.pos_y_out = o_reg[1];
    assign out.vel_x_out = o_reg[2];
    assign out.vel_y_out = o_reg[3];
    assign stat.busy     = state_reg != ST_IDLE;
    assign stat.done     = state_reg == ST_DONE;
endmodule
`default_nettype wire

// ===== test/nga_checker.sv =====
// Checker for the n-body gravity core: watches the operation and body-state
// channels and the register port, predicts each body state and compares.
// Depends on nga_pkg, nga_in_if and nga_out_if.
`timescale 1ns / 1ps
module nga_checker (
    input  logic        clk,
    input  logic        rst_n,
    nga_in_if           in_ch,
    nga_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending
);
    import nga_pkg::*;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] vel_x;
        logic [63:0] vel_y;
    } body_t;

    localparam logic [255:0] SOFTENING = ((256'd1 << 64) + 256'd5000) / 256'd10000;
    localparam logic [255:0] GRAV_Q64 = 256'd1230951232;

    body_t       body_q[$];
    logic [63:0] start_px, start_py, start_vx, start_vy;
    logic [62:0] dt_reg;
    logic [63:0] pos[2], vel[2], acc[2];

    function automatic logic [63:0] add_mag_sat(input logic [63:0] v, input logic neg,
                                                input logic [63:0] mag);
        logic [65:0] sum;
        sum = neg ? ({{2{v[63]}}, v} - {2'b00, mag}) : ({{2{v[63]}}, v} + {2'b00, mag});
        if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111)
            return sum[63:0];
        return sum[65] ? S64_MIN : S64_MAX;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [255:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [255:0] cw;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            cw = {192'd0, c};
            if (cw * cw <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] pull_mag(input logic [63:0] u, input logic [63:0] r,
                                             input logic [47:0] mass);
        logic [255:0] t;
        logic [255:0] rw;
        rw = {192'd0, r};
        t = ({192'd0, u} << 64) / rw;
        t = (t << FRAC_BITS) / rw;
        t = (t << FRAC_BITS) / rw;
        t = t * {208'd0, mass};
        t = t * GRAV_Q64;
        t = t >> (128 - FRAC_BITS);
        if (t[255:63] != '0)
            return S64_MAX;
        return t[63:0];
    endfunction

    function automatic logic [63:0] advance(input logic [63:0] v, input logic [63:0] rate,
                                            input logic [62:0] dt);
        logic [127:0] p;
        logic [63:0]  mag;
        p = ({64'd0, abs64(rate)} * {65'd0, dt}) >> FRAC_BITS;
        mag = (p[127:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
        return add_mag_sat(v, rate[63], mag);
    endfunction

    task automatic add_pull(input logic [63:0] ox, input logic [63:0] oy,
                            input logic [47:0] mass);
        logic [63:0]  d[2];
        logic [63:0]  u[2];
        logic [63:0]  r;
        logic [255:0] s;
        d[0] = add_mag_sat(ox, !pos[0][63], abs64(pos[0]));
        d[1] = add_mag_sat(oy, !pos[1][63], abs64(pos[1]));
        u[0] = abs64(d[0]);
        u[1] = abs64(d[1]);
        s = {192'd0, u[0]} * {192'd0, u[0]} + {192'd0, u[1]} * {192'd0, u[1]} + SOFTENING;
        r = root_floor(s);
        if (r == 0)
            r = 64'd1;
        for (int i = 0; i < 2; i++)
            if (u[i] != 0)
                acc[i] = add_mag_sat(acc[i], d[i][63], pull_mag(u[i], r, mass));
    endtask

    assign pending = body_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        body_t got;
        body_t want;
        if (!rst_n)
        begin
            errors <= 0;
            body_q.delete();
            {start_px, start_py, start_vx, start_vy, dt_reg} = '0;
            for (int i = 0; i < 2; i++)
            begin
                pos[i] = '0;
                vel[i] = '0;
                acc[i] = '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POS_X: start_px = cfg_data;
                    CFG_POS_Y: start_py = cfg_data;
                    CFG_VEL_X: start_vx = cfg_data;
                    CFG_VEL_Y: start_vy = cfg_data;
                    CFG_DT:    dt_reg = cfg_data[62:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.pos_x_out, out_ch.pos_y_out, out_ch.vel_x_out,
                        out_ch.vel_y_out};
                if (body_q.size() == 0)
                begin
                    $display("%0t: unexpected beat pos=(%h,%h) vel=(%h,%h)", $time,
                             got.pos_x, got.pos_y, got.vel_x, got.vel_y);
                    errors <= errors + 1;
                end
                else
                begin
                    want = body_q.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: expected pos=(%h,%h) vel=(%h,%h)", $time,
                                 want.pos_x, want.pos_y, want.vel_x, want.vel_y);
                        $display("%0t: actual   pos=(%h,%h) vel=(%h,%h)", $time,
                                 got.pos_x, got.pos_y, got.vel_x, got.vel_y);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (op_t'(in_ch.op))
                    OP_LOAD:
                    begin
                        pos[0] = start_px;
                        pos[1] = start_py;
                        vel[0] = start_vx;
                        vel[1] = start_vy;
                        acc[0] = '0;
                        acc[1] = '0;
                    end
                    OP_CLEAR:
                    begin
                        acc[0] = '0;
                        acc[1] = '0;
                    end
                    OP_FORCE: add_pull(in_ch.other_pos_x, in_ch.other_pos_y, in_ch.other_mass);
                    default:
                    begin
                        for (int i = 0; i < 2; i++)
                            vel[i] = advance(vel[i], acc[i], dt_reg);
                        for (int i = 0; i < 2; i++)
                            pos[i] = advance(pos[i], vel[i], dt_reg);
                    end
                endcase
                body_q.push_back('{pos[0], pos[1], vel[0], vel[1]});
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// Top of the n-body gravity core testbench: clock, reset, operation and register
// stimulus with random gaps and stalls, watchdog and verdict.
// Depends on nga_pkg, the channel interfaces, the core and nga_checker.
`timescale 1ns / 1ps
module tb;
    import nga_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    int          op_count[4] = '{0, 0, 0, 0};
    int          cfg_count = 0;
    bit          no_gaps = 1'b0;

    nga_in_if  in_ch ();
    nga_out_if out_ch ();

    nbody_gravity_accumulate_integrate_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nga_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #6 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.other_pos_x = '0;
        in_ch.other_pos_y = '0;
        in_ch.other_mass = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int n;
        @(negedge clk);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
            @(negedge clk);
        end
    end

    function automatic logic [63:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return S64_MAX;
            1:       return S64_MIN;
            2, 3:    return {$urandom, $urandom};
            default: return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)}
                            - (64'd1 << 39);
        endcase
    endfunction

    function automatic logic [47:0] rand_mass();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 48'hFFFF_FFFF_FFFF;
            2, 3:    return {16'($urandom), $urandom};
            default: return 48'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    function automatic logic [63:0] rand_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 1 << 30));
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        cfg_count++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_body(input logic [63:0] px, input logic [63:0] py,
                            input logic [63:0] vx, input logic [63:0] vy,
                            input logic [63:0] dt);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(CFG_POS_X, px);
        write_reg(CFG_POS_Y, py);
        write_reg(CFG_VEL_X, vx);
        write_reg(CFG_VEL_Y, vy);
        write_reg(CFG_DT, dt);
    endtask

    task automatic send(input op_t op, input logic [63:0] ox, input logic [63:0] oy,
                        input logic [47:0] mass);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 3);
        if (n > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_ch.op = op;
        in_ch.other_pos_x = ox;
        in_ch.other_pos_y = oy;
        in_ch.other_mass = mass;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        op_count[op]++;
        @(negedge clk);
    endtask

    initial
    begin
        int   pick;
        op_t  op;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_body(S64_MAX, S64_MIN, S64_MIN, S64_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_LOAD, '0, '0, '0);
        send(OP_STEP, '0, '0, '0);
        send(OP_FORCE, S64_MIN, S64_MAX, 48'hFFFF_FFFF_FFFF);
        send(OP_FORCE, S64_MAX, S64_MIN, 48'hFFFF_FFFF_FFFF);
        send(OP_STEP, '0, '0, '0);
        send(OP_CLEAR, '0, '0, '0);
        send(OP_STEP, '0, '0, '0);

        set_body('0, '0, 64'h0000_0001_0000_0000, '0, '0);
        write_reg(3'd5, {$urandom, $urandom});
        write_reg(3'd7, {$urandom, $urandom});
        send(OP_LOAD, '0, '0, '0);
        send(OP_FORCE, '0, '0, 48'hFFFF_FFFF_FFFF);
        send(OP_FORCE, 64'h0000_0003_0000_0000, 64'hFFFF_FFFC_0000_0000, '0);
        send(OP_FORCE, 64'h0000_0003_0000_0000, 64'hFFFF_FFFC_0000_0000, 48'd1000000);
        send(OP_FORCE, 64'h0000_0000_0000_0001, '0, 48'hFFFF_FFFF_FFFF);
        send(OP_STEP, '0, '0, '0);

        set_body(64'h0000_0010_0000_0000, 64'hFFFF_FFF0_0000_0000, '0, '0,
                 64'h0000_0000_1000_0000);
        send(OP_LOAD, '0, '0, '0);
        send(OP_FORCE, '0, '0, 48'hFFFF_FFFF_FFFF);
        send(OP_STEP, '0, '0, '0);
        send(OP_STEP, '0, '0, '0);
        send(OP_CLEAR, '0, '0, '0);
        send(OP_STEP, '0, '0, '0);

        for (int phase = 0; phase < 19; phase++)
        begin
            no_gaps = (phase % 5 == 2);
            if (phase % 6 == 5)
                set_body(S64_MIN, S64_MAX, S64_MAX, S64_MIN, rand_step());
            else
                set_body(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_step());
            send(OP_LOAD, '0, '0, '0);
            for (int k = 0; k < 99; k++)
            begin
                pick = $urandom_range(0, 99);
                op = (pick < 4) ? OP_LOAD : (pick < 14) ? OP_CLEAR :
                     (pick < 44) ? OP_FORCE : OP_STEP;
                if (op == OP_FORCE)
                    send(op, rand_coord(), rand_coord(), rand_mass());
                else
                    send(op, {$urandom, $urandom}, {$urandom, $urandom},
                         {16'($urandom), $urandom});
            end
        end
        in_ch.valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Run covered %0d loads, %0d clears, %0d forces, %0d steps",
                 op_count[OP_LOAD], op_count[OP_CLEAR], op_count[OP_FORCE],
                 op_count[OP_STEP]);
        $display("across %0d register writes with random gaps and stalls", cfg_count);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/nga_pkg.sv
src/nga_in_if.sv
src/nga_out_if.sv
src/nga_mul.sv
src/nga_div.sv
src/nga_sqrt.sv
src/nga_front.sv
src/nga_back.sv
src/nbody_gravity_accumulate_integrate_core.sv
test/nga_checker.sv
test/tb.sv
